// ----- sv/vu_meter_needle_ballistics_defines.svh -----
// Assertion macros for the VU meter needle ballistics block.
// Used by the port checker; the macros expect clk and rst in scope.
`ifndef VU_METER_NEEDLE_BALLISTICS_DEFINES_SVH
`define VU_METER_NEEDLE_BALLISTICS_DEFINES_SVH

// Same-cycle implication, off while in reset
`define VU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset
`define VU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/vu_pkg.sv -----
// Shared constants, types and codes for the VU meter needle ballistics block.
// No dependencies; every other file but the assertion macros header imports this package.
`default_nettype none

package vu_pkg;

  // Fixed-point position resolution (fraction bits of arc position)
  localparam int FRAC_BITS = 14;

  // Field widths
  localparam int RMS_W  = 16;
  localparam int COEF_W = 16;
  localparam int MAXD_W = 15;
  localparam int ARC_W  = 11;
  localparam int ANG_W  = 12;
  localparam int VEL_W  = 24;

  // Position is 0..max, max below 2^(FRAC_BITS+1)
  localparam int POS_W = FRAC_BITS + 1;

  // Shared multiplier operands and product
  localparam int MA_W   = VEL_W + 1;
  localparam int MB_W   = COEF_W + 1;
  localparam int PROD_W = MA_W + MB_W;
  localparam int ACC_W  = PROD_W + 1;

  // Rounding shifts
  localparam int TGT_SH = 28 - FRAC_BITS;
  localparam int VEL_SH = 12;
  localparam int POS_SH = 16;

  // max_deflection is Q1.14; rescale to FRAC_BITS
  localparam int MX_SHL = (FRAC_BITS >= 14) ? FRAC_BITS - 14 : 0;
  localparam int MX_SHR = (FRAC_BITS >= 14) ? 0 : 14 - FRAC_BITS;
  localparam int MXW    = MAXD_W + MX_SHL;

  // Position update sum, and rounded angle before wrap (|r| <= 3 * arc)
  localparam int PN_W  = VEL_W + 2;
  localparam int RND_W = ARC_W + 3;

  localparam int ANG_MOD = 3600;
  localparam logic [ANG_W-1:0] NO_ANGLE = '1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPRING_COEFF    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING_COEFF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DEFLECTION  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ARC_HALF_TENTHS = 3'd5;

  localparam logic [COEF_W-1:0] RST_TARGET_GAIN     = 16'd14578;
  localparam logic [COEF_W-1:0] RST_SPRING_COEFF    = 16'd30106;
  localparam logic [COEF_W-1:0] RST_DAMPING_COEFF   = 16'd2322;
  localparam logic [COEF_W-1:0] RST_STEP_TIME       = 16'd1092;
  localparam logic [MAXD_W-1:0] RST_MAX_DEFLECTION  = 15'd16876;
  localparam logic [ARC_W-1:0]  RST_ARC_HALF_TENTHS = 11'd450;

  typedef struct packed {
    logic [COEF_W-1:0] target_gain;
    logic [COEF_W-1:0] spring_coeff;
    logic [COEF_W-1:0] damping_coeff;
    logic [COEF_W-1:0] step_time;
    logic [MAXD_W-1:0] max_deflection;
    logic [ARC_W-1:0]  arc_half_tenths;
  } cfg_t;

  // Datapath step codes, in sequence order (sequencer steps by +1)
  typedef enum logic [3:0] {
    OP_NONE,
    OP_T_MUL,   // rms * gain
    OP_T_SAT,   // round, saturate -> target
    OP_S_MUL,   // spring * (target - pos)
    OP_D_MUL,   // damping * vel, latch spring product
    OP_V_SUM,   // spring term - damping term + half
    OP_V_UPD,   // vel += sum >> 12, saturate
    OP_P_MUL,   // vel * step_time
    OP_P_RND,   // add half
    OP_P_UPD,   // pos += delta, clamp
    OP_A_MUL,   // pos * 2A
    OP_A_NUM,   // subtract A << FRAC_BITS
    OP_A_RND,   // round to nearest, ties away from zero
    OP_A_WRAP   // wrap into 0..3599
  } op_t;

  typedef struct packed {
    logic load;   // input word taken this cycle
    logic emit;   // result moves to the output register this cycle
    logic ch;     // 0 left, 1 right
    op_t  op;
  } ctrl_t;

  typedef struct packed {
    logic [ANG_W-1:0] angle_left;
    logic [ANG_W-1:0] angle_right;
    logic             moved_left;
    logic             moved_right;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/vu_ifaces.sv -----
// Valid/ready channel interfaces for the needle ballistics block.
// Depends on vu_pkg for field widths.
`default_nettype none

interface vu_in_if;
  import vu_pkg::*;
  logic             valid;
  logic             ready;
  logic [RMS_W-1:0] rms_left;
  logic [RMS_W-1:0] rms_right;

  modport source (output valid, rms_left, rms_right, input ready);
  modport sink   (input valid, rms_left, rms_right, output ready);
endinterface

interface vu_out_if;
  import vu_pkg::*;
  logic             valid;
  logic             ready;
  logic [ANG_W-1:0] angle_left;
  logic [ANG_W-1:0] angle_right;
  logic             moved_left;
  logic             moved_right;

  modport source (output valid, angle_left, angle_right, moved_left, moved_right,
                  input ready);
  modport sink   (input valid, angle_left, angle_right, moved_left, moved_right,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/vu_mul.sv -----
// Shared signed multiplier with registered product.
// Depends on vu_pkg for operand widths.
`default_nettype none

module vu_mul (
  input  wire logic                               clk,
  input  wire logic signed [vu_pkg::MA_W-1:0]     a,
  input  wire logic signed [vu_pkg::MB_W-1:0]     b,
  output logic signed      [vu_pkg::PROD_W-1:0]   prod
);
  import vu_pkg::*;

  // one multiply per cycle, registered product
  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

`default_nettype wire

// ----- sv/vu_ctrl.sv -----
// Sequencer: steps the datapath through both channels, one op per cycle.
// Depends on vu_pkg for op_t and ctrl_t.
`default_nettype none

module vu_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          out_free,
  output logic               in_ready,
  output vu_pkg::ctrl_t      ctrl
);
  import vu_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_HOLD} state_t;

  state_t state;
  op_t    op;
  logic   ch;

  assign in_ready  = (state == ST_IDLE);
  assign ctrl.load = in_valid && in_ready;
  assign ctrl.emit = (state == ST_HOLD) && out_free;
  assign ctrl.ch   = ch;
  assign ctrl.op   = op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= OP_NONE;
      ch    <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_RUN;
            op    <= OP_T_MUL;
            ch    <= 1'b0;
          end
        end
        ST_RUN: begin
          if (op == OP_A_WRAP) begin
            // left done: start right; right done: wait for output slot
            if (!ch) begin
              ch <= 1'b1;
              op <= OP_T_MUL;
            end else begin
              state <= ST_HOLD;
              op    <= OP_NONE;
            end
          end else begin
            op <= op_t'(4'(op) + 4'd1);
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
          op    <= OP_NONE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/vu_dpath.sv -----
// Datapath: per-channel needle state, operand select for the shared
// multiplier, rounding/saturation steps. Depends on vu_pkg and vu_mul.
`default_nettype none

module vu_dpath (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire vu_pkg::ctrl_t             ctrl,
  input  wire vu_pkg::cfg_t              cfg,
  input  wire logic [vu_pkg::RMS_W-1:0]  rms_left,
  input  wire logic [vu_pkg::RMS_W-1:0]  rms_right,
  output vu_pkg::result_t                result
);
  import vu_pkg::*;

  localparam logic signed [PROD_W-1:0] TGT_HALF    = PROD_W'(1) << (TGT_SH - 1);
  localparam logic signed [ACC_W-1:0]  VEL_HALF    = ACC_W'(1) << (VEL_SH - 1);
  localparam logic signed [ACC_W-1:0]  POS_HALF    = ACC_W'(1) << (POS_SH - 1);
  localparam logic signed [ACC_W-1:0]  ANG_HALF    = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0]  ANG_HALF_M1 = ANG_HALF - ACC_W'(1);
  localparam logic signed [ACC_W-1:0]  VEL_MAX_A   =
    $signed({{(ACC_W-VEL_W+1){1'b0}}, {(VEL_W-1){1'b1}}});
  localparam logic signed [ACC_W-1:0]  VEL_MIN_A   =
    $signed({{(ACC_W-VEL_W+1){1'b1}}, {(VEL_W-1){1'b0}}});
  localparam logic signed [RND_W-1:0]  MOD_S       = RND_W'(ANG_MOD);

  // needle state
  logic        [POS_W-1:0] pos [2];
  logic signed [VEL_W-1:0] vel [2];
  logic        [ANG_W-1:0] last_angle [2];

  // working registers
  logic        [RMS_W-1:0] rms_l, rms_r;
  logic        [POS_W-1:0] tgt;
  logic signed [ACC_W-1:0] acc;
  logic signed [RND_W-1:0] rnd;
  logic        [ANG_W-1:0] angle [2];

  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod;

  logic        [POS_W-1:0]  p_cur;
  logic signed [VEL_W-1:0]  v_cur;
  logic        [RMS_W-1:0]  rms_cur;
  logic        [MXW-1:0]    mx_wide;
  logic        [POS_W-1:0]  mx;
  logic signed [POS_W:0]    diff;

  logic signed [PROD_W-1:0] tgt_q;
  logic        [POS_W-1:0]  tgt_next;
  logic signed [ACC_W-1:0]  vsum;
  logic signed [VEL_W-1:0]  v_sat;
  logic signed [PN_W-1:0]   pn;
  logic        [POS_W-1:0]  p_next;
  logic signed [VEL_W-1:0]  v_next;
  logic signed [ACC_W-1:0]  ang_adj;
  logic        [ANG_W-1:0]  wrap_next;
  logic [ARC_W+FRAC_BITS-1:0] arc_sh;

  assign p_cur   = pos[ctrl.ch];
  assign v_cur   = vel[ctrl.ch];
  assign rms_cur = ctrl.ch ? rms_r : rms_l;

  // max deflection rescaled to FRAC_BITS
  assign mx_wide = MXW'(cfg.max_deflection) << MX_SHL;
  assign mx      = POS_W'(mx_wide >> MX_SHR);
  assign diff    = $signed({1'b0, tgt}) - $signed({1'b0, p_cur});
  assign arc_sh  = {cfg.arc_half_tenths, {FRAC_BITS{1'b0}}};

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl.op)
      OP_T_MUL: begin
        mul_a = $signed(MA_W'(rms_cur));
        mul_b = $signed({1'b0, cfg.target_gain});
      end
      OP_S_MUL: begin
        mul_a = MA_W'(diff);
        mul_b = $signed({1'b0, cfg.spring_coeff});
      end
      OP_D_MUL: begin
        mul_a = MA_W'(v_cur);
        mul_b = $signed({1'b0, cfg.damping_coeff});
      end
      OP_P_MUL: begin
        mul_a = MA_W'(v_cur);
        mul_b = $signed({1'b0, cfg.step_time});
      end
      OP_A_MUL: begin
        mul_a = $signed(MA_W'(p_cur));
        mul_b = $signed(MB_W'({cfg.arc_half_tenths, 1'b0}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  vu_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // target: round half up, saturate at max
  always_comb begin
    tgt_q = (prod + TGT_HALF) >>> TGT_SH;
    if (tgt_q > $signed(PROD_W'(mx))) begin
      tgt_next = mx;
    end else begin
      tgt_next = POS_W'(tgt_q);
    end
  end

  // velocity: add rounded term, saturate to VEL_W
  always_comb begin
    vsum = ACC_W'(v_cur) + (acc >>> VEL_SH);
    if (vsum > VEL_MAX_A) begin
      v_sat = VEL_W'(VEL_MAX_A);
    end else if (vsum < VEL_MIN_A) begin
      v_sat = VEL_W'(VEL_MIN_A);
    end else begin
      v_sat = VEL_W'(vsum);
    end
  end

  // position: add delta, clamp to 0..max, kill velocity into a bound
  always_comb begin
    pn     = $signed(PN_W'(p_cur)) + PN_W'(acc >>> POS_SH);
    p_next = POS_W'(pn);
    v_next = v_cur;
    priority if (pn < 0) begin
      p_next = '0;
      if (v_cur < 0) v_next = '0;
    end else if (pn > $signed(PN_W'(mx))) begin
      p_next = mx;
      if (v_cur > 0) v_next = '0;
    end
  end

  // angle rounding bias: ties away from zero
  assign ang_adj = acc[ACC_W-1] ? ANG_HALF_M1 : ANG_HALF;

  // wrap into 0..3599 (one correction is enough for |r| <= 3 * arc)
  always_comb begin
    priority if (rnd < 0) begin
      wrap_next = ANG_W'(rnd + MOD_S);
    end else if (rnd >= MOD_S) begin
      wrap_next = ANG_W'(rnd - MOD_S);
    end else begin
      wrap_next = ANG_W'(rnd);
    end
  end

  // needle state and last delivered angles
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        pos[i]        <= '0;
        vel[i]        <= '0;
        last_angle[i] <= NO_ANGLE;
      end
    end else begin
      if (ctrl.op == OP_V_UPD) begin
        vel[ctrl.ch] <= v_sat;
      end
      if (ctrl.op == OP_P_UPD) begin
        pos[ctrl.ch] <= p_next;
        vel[ctrl.ch] <= v_next;
      end
      if (ctrl.emit) begin
        last_angle[0] <= angle[0];
        last_angle[1] <= angle[1];
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rms_l <= rms_left;
      rms_r <= rms_right;
    end
    unique case (ctrl.op)
      OP_T_SAT:  tgt <= tgt_next;
      OP_D_MUL:  acc <= ACC_W'(prod);
      OP_V_SUM:  acc <= acc - ACC_W'(prod) + VEL_HALF;
      OP_P_RND:  acc <= ACC_W'(prod) + POS_HALF;
      OP_A_NUM:  acc <= ACC_W'(prod) - $signed(ACC_W'(arc_sh));
      OP_A_RND:  rnd <= RND_W'((acc + ang_adj) >>> FRAC_BITS);
      OP_A_WRAP: angle[ctrl.ch] <= wrap_next;
      default: ;
    endcase
  end

  assign result.angle_left  = angle[0];
  assign result.angle_right = angle[1];
  assign result.moved_left  = (angle[0] != last_angle[0]);
  assign result.moved_right = (angle[1] != last_angle[1]);

endmodule

`default_nettype wire

// ----- sv/vu_meter_needle_ballistics.sv -----
// Top level of the stereo VU meter needle ballistics block.
// Depends on vu_pkg, vu_ifaces, vu_ctrl, vu_dpath (and vu_mul below it).
//
//  port       dir  word                                        handshake
//  meter_in   in   rms_left, rms_right (Q0.16)                 valid/ready
//  meter_out  out  angle_left/right, moved_left/right          valid/ready
//  cfg_*      in   cfg_index, cfg_data                         cfg_we, no stall
//
// One multiplier is shared by the multiply steps of 13 steps per channel,
// left then right. A word is taken in the cycle ready is high; its result
// passes through both channel sequences and the hold state to the output
// register, and no new word is taken until the sequencer is back in idle.
// A stalled result holds the sequencer until the output register frees.
// Reset is synchronous and clears needle state and config to defaults.
`default_nettype none

module vu_meter_needle_ballistics (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [vu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [vu_pkg::CFG_DATA_W-1:0]  cfg_data,
  vu_in_if.sink                               meter_in,
  vu_out_if.source                            meter_out
);
  import vu_pkg::*;

  cfg_t    cfg;
  ctrl_t   ctrl;
  result_t result;
  logic    in_ready;
  logic    out_valid;
  logic    out_free;
  result_t out_word;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_gain     <= RST_TARGET_GAIN;
      cfg.spring_coeff    <= RST_SPRING_COEFF;
      cfg.damping_coeff   <= RST_DAMPING_COEFF;
      cfg.step_time       <= RST_STEP_TIME;
      cfg.max_deflection  <= RST_MAX_DEFLECTION;
      cfg.arc_half_tenths <= RST_ARC_HALF_TENTHS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET_GAIN:     cfg.target_gain     <= cfg_data;
        REG_SPRING_COEFF:    cfg.spring_coeff    <= cfg_data;
        REG_DAMPING_COEFF:   cfg.damping_coeff   <= cfg_data;
        REG_STEP_TIME:       cfg.step_time       <= cfg_data;
        REG_MAX_DEFLECTION:  cfg.max_deflection  <= cfg_data[MAXD_W-1:0];
        REG_ARC_HALF_TENTHS: cfg.arc_half_tenths <= cfg_data[ARC_W-1:0];
        default: ;
      endcase
    end
  end

  assign meter_in.ready = in_ready;
  assign out_free       = !out_valid || meter_out.ready;

  vu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (meter_in.valid),
    .out_free (out_free),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  vu_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .cfg       (cfg),
    .rms_left  (meter_in.rms_left),
    .rms_right (meter_in.rms_right),
    .result    (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid <= 1'b1;
    end else if (meter_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_word <= result;
    end
  end

  assign meter_out.valid       = out_valid;
  assign meter_out.angle_left  = out_word.angle_left;
  assign meter_out.angle_right = out_word.angle_right;
  assign meter_out.moved_left  = out_word.moved_left;
  assign meter_out.moved_right = out_word.moved_right;

endmodule

`default_nettype wire

// ----- sv/vu_meter_needle_ballistics_chk.sv -----
// Port-level checker for the needle ballistics block, bound to the top.
// Depends on vu_pkg and the assertion macros header.
`default_nettype none
`include "vu_meter_needle_ballistics_defines.svh"

module vu_meter_needle_ballistics_chk (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [vu_pkg::ANG_W-1:0]  angle_left,
  input wire logic [vu_pkg::ANG_W-1:0]  angle_right,
  input wire logic                      moved_left,
  input wire logic                      moved_right
);
  import vu_pkg::*;

  // stalled result word holds
  `VU_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(angle_left) && $stable(angle_right) && $stable(moved_left) && $stable(moved_right), "output word changed while stalled")

  // a taken word keeps the block busy
  `VU_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready, "ready right after taking a word")

  // angles always wrapped
  `VU_ASSERT_IMP(a_angle_range, out_valid, (angle_left < 12'd3600) && (angle_right < 12'd3600), "angle out of range")

  // a new result means the sequencer has gone back to idle
  `VU_ASSERT_IMP(a_idle_on_result, $rose(out_valid), in_ready, "result shown while still busy")

endmodule

bind vu_meter_needle_ballistics vu_meter_needle_ballistics_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (meter_in.valid),
  .in_ready    (meter_in.ready),
  .out_valid   (meter_out.valid),
  .out_ready   (meter_out.ready),
  .angle_left  (meter_out.angle_left),
  .angle_right (meter_out.angle_right),
  .moved_left  (meter_out.moved_left),
  .moved_right (meter_out.moved_right)
);

`default_nettype wire

// ----- bench/tb_vu_meter_needle_ballistics.sv -----
`timescale 1ns / 100ps
// Testbench for the stereo VU meter needle ballistics block.
// Depends on vu_pkg and the vu_in_if / vu_out_if channels; predicts the needle
// physics in fixed point and checks every result word against the prediction.

module tb_vu_meter_needle_ballistics;
  import vu_pkg::*;

  localparam int     CLK_HALF     = 5;
  localparam longint RUN_LIMIT    = 1000000;
  localparam int     DRAIN_CYCLES = 40;
  localparam int     RANDOM_PHASES = 11;
  localparam int     PHASE_FRAMES  = 100;

  localparam longint VEL_HI = (longint'(1) << (VEL_W - 1)) - 1;
  localparam longint VEL_LO = -(longint'(1) << (VEL_W - 1));

  localparam cfg_t DEFAULT_SETTING = '{
    target_gain:     RST_TARGET_GAIN,
    spring_coeff:    RST_SPRING_COEFF,
    damping_coeff:   RST_DAMPING_COEFF,
    step_time:       RST_STEP_TIME,
    max_deflection:  RST_MAX_DEFLECTION,
    arc_half_tenths: RST_ARC_HALF_TENTHS
  };

  // Shapes of level program segments
  typedef enum int {SEG_HOLD, SEG_JITTER, SEG_RAMP, SEG_NOISE} seg_kind_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  vu_in_if  meter_in_bus();
  vu_out_if meter_out_bus();

  vu_meter_needle_ballistics u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .meter_in  (meter_in_bus),
    .meter_out (meter_out_bus)
  );

  always #CLK_HALF clk = ~clk;

  // Predicted needle state and the block's register settings
  cfg_t             needle_cfg;
  longint           pos_l, vel_l, pos_r, vel_r;
  logic [ANG_W-1:0] last_ang_l, last_ang_r;

  result_t pending_angles[$];
  int      mismatch_count = 0;
  longint  cycle_count = 0;
  bit      steady = 1'b0;   // no idling on either side while set

  function automatic longint round_half_up(longint x, int n);
    return (x + (longint'(1) << (n - 1))) >>> n;
  endfunction

  // One spring-damper step of a single needle
  function automatic void step_needle(input logic [RMS_W-1:0] rms, inout longint pos,
                                      inout longint vel);
    longint top, tgt, drive_sum;
    top = (longint'(needle_cfg.max_deflection) << MX_SHL) >> MX_SHR;
    tgt = round_half_up(longint'(rms) * longint'(needle_cfg.target_gain), TGT_SH);
    if (tgt > top) tgt = top;
    drive_sum = longint'(needle_cfg.spring_coeff) * (tgt - pos)
              - longint'(needle_cfg.damping_coeff) * vel;
    vel += round_half_up(drive_sum, VEL_SH);
    if (vel > VEL_HI) vel = VEL_HI;
    if (vel < VEL_LO) vel = VEL_LO;
    pos += round_half_up(vel * longint'(needle_cfg.step_time), POS_SH);
    if (pos < 0) begin
      pos = 0;
      if (vel < 0) vel = 0;
    end
    if (pos > top) begin
      pos = top;
      if (vel > 0) vel = 0;
    end
  endfunction

  // Position to angle in tenths of a degree, ties away from zero, wrapped
  function automatic logic [ANG_W-1:0] needle_angle(longint pos);
    longint arc, num, half, r;
    arc  = longint'(needle_cfg.arc_half_tenths);
    num  = pos * 2 * arc - (arc << FRAC_BITS);
    half = longint'(1) << (FRAC_BITS - 1);
    if (num >= 0) r = (num + half) >>> FRAC_BITS;
    else r = -((half - num) >>> FRAC_BITS);
    r = r % ANG_MOD;
    if (r < 0) r += ANG_MOD;
    return r[ANG_W-1:0];
  endfunction

  function automatic result_t advance_needles(logic [RMS_W-1:0] lvl_l, logic [RMS_W-1:0] lvl_r);
    result_t res;
    step_needle(lvl_l, pos_l, vel_l);
    step_needle(lvl_r, pos_r, vel_r);
    res.angle_left  = needle_angle(pos_l);
    res.angle_right = needle_angle(pos_r);
    res.moved_left  = (res.angle_left != last_ang_l);
    res.moved_right = (res.angle_right != last_ang_r);
    last_ang_l = res.angle_left;
    last_ang_r = res.angle_right;
    return res;
  endfunction

  function automatic void reset_needles();
    needle_cfg = DEFAULT_SETTING;
    pos_l = 0;
    vel_l = 0;
    pos_r = 0;
    vel_r = 0;
    last_ang_l = NO_ANGLE;
    last_ang_r = NO_ANGLE;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 20);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [RMS_W-1:0] clip_level(int lvl);
    if (lvl < 0) return '0;
    if (lvl > 65535) return '1;
    return lvl[RMS_W-1:0];
  endfunction

  function automatic int pick_level();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 0;
    if (roll == 1) return 65535;
    if (roll < 5) return $urandom_range(0, 65535);
    return $urandom_range(1000, 25000);   // typical program level
  endfunction

  // Send one word; the prediction is taken at the accepting edge
  task automatic send_word(input logic [RMS_W-1:0] lvl_l, input logic [RMS_W-1:0] lvl_r);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      meter_in_bus.valid <= 1'b0;
    end
    @(negedge clk);
    meter_in_bus.valid     <= 1'b1;
    meter_in_bus.rms_left  <= lvl_l;
    meter_in_bus.rms_right <= lvl_r;
    do @(posedge clk); while (meter_in_bus.ready !== 1'b1);
    pending_angles.push_back(advance_needles(lvl_l, lvl_r));
  endtask

  // Stop sending and wait until every predicted word has come back
  task automatic wait_idle();
    @(negedge clk);
    meter_in_bus.valid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Write all six registers while the block is idle
  task automatic apply_setting(input cfg_t s);
    wait_idle();
    put_reg(REG_TARGET_GAIN, s.target_gain);
    put_reg(REG_SPRING_COEFF, s.spring_coeff);
    put_reg(REG_DAMPING_COEFF, s.damping_coeff);
    put_reg(REG_STEP_TIME, s.step_time);
    put_reg(REG_MAX_DEFLECTION, CFG_DATA_W'(s.max_deflection));
    put_reg(REG_ARC_HALF_TENTHS, CFG_DATA_W'(s.arc_half_tenths));
    @(negedge clk);
    cfg_we <= 1'b0;
    needle_cfg = s;
  endtask

  function automatic cfg_t random_setting();
    cfg_t s;
    int   mode;
    mode = $urandom_range(0, 9);
    if (mode < 6) begin
      // plausible meter tuning
      s.target_gain     = COEF_W'($urandom_range(8000, 30000));
      s.spring_coeff    = COEF_W'($urandom_range(2000, 40000));
      s.damping_coeff   = COEF_W'($urandom_range(300, 9000));
      s.step_time       = COEF_W'($urandom_range(300, 4000));
      s.max_deflection  = MAXD_W'($urandom_range(6000, 32767));
      s.arc_half_tenths = ARC_W'($urandom_range(100, 1800));
    end else if (mode < 8) begin
      s.target_gain     = COEF_W'($urandom);
      s.spring_coeff    = COEF_W'($urandom);
      s.damping_coeff   = COEF_W'($urandom);
      s.step_time       = COEF_W'($urandom);
      s.max_deflection  = MAXD_W'($urandom);
      s.arc_half_tenths = ARC_W'($urandom);
    end else begin
      // each field at one end of its range
      s.target_gain     = $urandom_range(0, 1) ? '1 : '0;
      s.spring_coeff    = $urandom_range(0, 1) ? '1 : '0;
      s.damping_coeff   = $urandom_range(0, 1) ? '1 : '0;
      s.step_time       = $urandom_range(0, 1) ? '1 : '0;
      s.max_deflection  = $urandom_range(0, 1) ? '1 : '0;
      s.arc_half_tenths = $urandom_range(0, 1) ? '1 : '0;
    end
    return s;
  endfunction

  // Level program: held levels, jitter, ramps and bursts of noise
  task automatic drive_program(input int frames);
    seg_kind_t kind;
    int        roll, seg_len, k, sent, base_l, base_r, slope_l, slope_r;
    sent = 0;
    while (sent < frames) begin
      roll = $urandom_range(0, 9);
      kind = (roll < 3) ? SEG_HOLD : (roll < 6) ? SEG_JITTER : (roll < 8) ? SEG_RAMP : SEG_NOISE;
      seg_len = $urandom_range(1, 40);
      base_l  = pick_level();
      base_r  = pick_level();
      slope_l = $urandom_range(0, 4000) - 2000;
      slope_r = $urandom_range(0, 4000) - 2000;
      for (k = 0; k < seg_len && sent < frames; k++) begin
        case (kind)
          SEG_HOLD: send_word(clip_level(base_l), clip_level(base_r));
          SEG_JITTER: send_word(clip_level(base_l + $urandom_range(0, 1023) - 512),
                                clip_level(base_r + $urandom_range(0, 1023) - 512));
          SEG_RAMP: send_word(clip_level(base_l + k * slope_l), clip_level(base_r + k * slope_r));
          default: send_word(RMS_W'($urandom), RMS_W'($urandom));
        endcase
        sent++;
      end
    end
  endtask

  // First frames after reset, rest and full scale on each side
  task automatic test_first_frames();
    send_word(16'd0, 16'd0);
    send_word(16'd0, 16'd0);
    repeat (3) send_word(16'hFFFF, 16'd0);
    send_word(16'd0, 16'hFFFF);
    repeat (2) send_word(16'hFFFF, 16'hFFFF);
  endtask

  // Zero maximum deflection pins both needles at rest
  task automatic test_pinned_needle();
    cfg_t s;
    s = DEFAULT_SETTING;
    s.max_deflection = '0;
    apply_setting(s);
    repeat (2) send_word(16'hFFFF, 16'hFFFF);
    send_word(16'd0, 16'd0);
  endtask

  // Hard drive with a sweep above range, at the top of range and of zero width
  task automatic test_wide_sweep();
    cfg_t s;
    s = '{target_gain: '1, spring_coeff: '1, damping_coeff: 16'd0, step_time: '1,
          max_deflection: '1, arc_half_tenths: '1};
    apply_setting(s);
    repeat (3) send_word(16'hFFFF, 16'hFFFF);
    s.arc_half_tenths = 11'd1800;
    apply_setting(s);
    send_word(16'hFFFF, 16'h8000);
    s.arc_half_tenths = '0;
    apply_setting(s);
    send_word(16'h8000, 16'h0001);
  endtask

  // Zero coefficients freeze the needle; full ones slam the velocity limits
  task automatic test_frozen_needle();
    cfg_t s;
    s = '{target_gain: '0, spring_coeff: '0, damping_coeff: '0, step_time: '0,
          max_deflection: '1, arc_half_tenths: RST_ARC_HALF_TENTHS};
    apply_setting(s);
    repeat (2) send_word(16'hFFFF, 16'hFFFF);
    s = '{target_gain: '1, spring_coeff: '1, damping_coeff: '1, step_time: '1,
          max_deflection: '1, arc_half_tenths: RST_ARC_HALF_TENTHS};
    apply_setting(s);
    send_word(16'hFFFF, 16'd0);
    send_word(16'd0, 16'hFFFF);
    send_word(16'hFFFF, 16'd0);
    send_word(16'd0, 16'hFFFF);
  endtask

  // Random phases: new tuning each phase, level programs within
  task automatic test_random_phases();
    int phase;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      apply_setting((phase == 0) ? DEFAULT_SETTING : random_setting());
      steady = (phase == 1) || ($urandom_range(0, 4) == 0);
      drive_program(PHASE_FRAMES);
      steady = 1'b0;
    end
  endtask

  // Receiver: random stalls on ready
  initial begin
    int stall;
    meter_out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = pick_gap();
      if (stall == 0) begin
        meter_out_bus.ready <= 1'b1;
      end else begin
        meter_out_bus.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  task automatic report_field(input string name, input logic [ANG_W-1:0] want,
                              input logic [ANG_W-1:0] got);
    $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    mismatch_count++;
  endtask

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && meter_out_bus.valid === 1'b1 && meter_out_bus.ready === 1'b1) begin
      got.angle_left  = meter_out_bus.angle_left;
      got.angle_right = meter_out_bus.angle_right;
      got.moved_left  = meter_out_bus.moved_left;
      got.moved_right = meter_out_bus.moved_right;
      if (pending_angles.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got %p", $time, got);
        mismatch_count++;
      end else begin
        want = pending_angles.pop_front();
        if (got.angle_left !== want.angle_left)
          report_field("angle_left", want.angle_left, got.angle_left);
        if (got.angle_right !== want.angle_right)
          report_field("angle_right", want.angle_right, got.angle_right);
        if (got.moved_left !== want.moved_left)
          report_field("moved_left", ANG_W'(want.moved_left), ANG_W'(got.moved_left));
        if (got.moved_right !== want.moved_right)
          report_field("moved_right", ANG_W'(want.moved_right), ANG_W'(got.moved_right));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("tb_vu_meter_needle_ballistics: errors");
      $finish;
    end
  end

  // Test sequence
  initial begin
    meter_in_bus.valid     = 1'b0;
    meter_in_bus.rms_left  = '0;
    meter_in_bus.rms_right = '0;
    reset_needles();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_first_frames();
    test_pinned_needle();
    test_wide_sweep();
    test_frozen_needle();
    test_random_phases();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_angles.size() == 0)
      $display("tb_vu_meter_needle_ballistics: clean");
    else
      $display("tb_vu_meter_needle_ballistics: errors");
    $finish;
  end

endmodule
